@@ design/e8cpu_pkg.sv @@
// Shared types and operation codes for the 8-bit CPU execute unit.
package e8cpu_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
      OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
      OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
      OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
      OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
      OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
      OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
      OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
      OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
      OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
      OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
      OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
      OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
      OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
   } op_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0]  SP_RESET    = 8'hFD;
   localparam logic [7:0]  FLAGS_RESET = 8'h24;
   localparam logic [15:0] STACK_BASE  = 16'h0100;

   typedef struct packed {
      logic [5:0]  req_type;
      logic        accumulator_mode;
      logic [15:0] operand_address;
      logic [7:0]  operand_byte;
      logic [15:0] pc_now;
      logic [7:0]  stack_byte_one;
      logic [7:0]  stack_byte_two;
      logic [7:0]  stack_byte_three;
   } req_type_t_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] flags;
   } arch_type;

   // Everything one request produces, before it is split into write results.
   typedef struct packed {
      arch_type    arch;
      logic [1:0]  wr_count;
      logic [15:0] wr_addr0;
      logic [15:0] wr_addr1;
      logic [15:0] wr_addr2;
      logic [7:0]  wr_data0;
      logic [7:0]  wr_data1;
      logic [7:0]  wr_data2;
      logic        pc_load;
      logic [15:0] next_pc;
      logic        extra_cycle;
      logic        break_hit;
   } exec_type;

endpackage

@@ design/e8cpu_alu.sv @@
// Combinational execution of one operation against the register file.
module e8cpu_alu (
   input  e8cpu_pkg::req_type_t_type req,
   input  e8cpu_pkg::arch_type       cur,
   output e8cpu_pkg::exec_type       res
);

   logic [7:0] a, f, v, m, sh, sp, push_f, pulled;
   logic [8:0] sum;
   logic [15:0] t_brk, t_jsr;
   logic take, branch;

   always_comb begin
      a      = cur.acc;
      f      = cur.flags;
      m      = req.operand_byte;
      sp     = cur.sp;
      push_f = cur.flags | 8'h30;
      pulled = (req.stack_byte_one & 8'hEF) | 8'h20;
      t_brk  = req.pc_now + 16'd2;
      t_jsr  = req.pc_now - 16'd1;
      sh     = req.accumulator_mode ? a : m;
      v      = 8'h00;
      sum    = 9'h000;
      take   = 1'b0;
      branch = 1'b0;
      res = '0;
      res.arch = cur;
      unique case (req.req_type)
         e8cpu_pkg::OP_ADC, e8cpu_pkg::OP_SBC: begin
            v   = (req.req_type == e8cpu_pkg::OP_SBC) ? ~m : m;
            sum = {1'b0, a} + {1'b0, v} + {8'h00, f[e8cpu_pkg::FLAG_C]};
            res.arch.flags[e8cpu_pkg::FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
            res.arch.flags[e8cpu_pkg::FLAG_C] = sum[8];
            res.arch.acc = sum[7:0];
         end
         e8cpu_pkg::OP_AND: res.arch.acc = a & m;
         e8cpu_pkg::OP_EOR: res.arch.acc = a ^ m;
         e8cpu_pkg::OP_ORA: res.arch.acc = a | m;
         e8cpu_pkg::OP_ASL, e8cpu_pkg::OP_LSR, e8cpu_pkg::OP_ROL, e8cpu_pkg::OP_ROR: begin
            unique case (req.req_type)
               e8cpu_pkg::OP_ASL: begin
                  res.arch.flags[e8cpu_pkg::FLAG_C] = sh[7];
                  v = {sh[6:0], 1'b0};
               end
               e8cpu_pkg::OP_LSR: begin
                  res.arch.flags[e8cpu_pkg::FLAG_C] = sh[0];
                  v = {1'b0, sh[7:1]};
               end
               e8cpu_pkg::OP_ROL: begin
                  res.arch.flags[e8cpu_pkg::FLAG_C] = sh[7];
                  v = {sh[6:0], f[e8cpu_pkg::FLAG_C]};
               end
               default: begin
                  res.arch.flags[e8cpu_pkg::FLAG_C] = sh[0];
                  v = {f[e8cpu_pkg::FLAG_C], sh[7:1]};
               end
            endcase
            if (req.accumulator_mode) begin
               res.arch.acc = v;
            end else begin
               res.wr_count = 2'd1;
               res.wr_addr0 = req.operand_address;
               res.wr_data0 = v;
            end
         end
         e8cpu_pkg::OP_BCC: begin branch = 1'b1; take = ~f[e8cpu_pkg::FLAG_C]; end
         e8cpu_pkg::OP_BCS: begin branch = 1'b1; take =  f[e8cpu_pkg::FLAG_C]; end
         e8cpu_pkg::OP_BEQ: begin branch = 1'b1; take =  f[e8cpu_pkg::FLAG_Z]; end
         e8cpu_pkg::OP_BMI: begin branch = 1'b1; take =  f[e8cpu_pkg::FLAG_N]; end
         e8cpu_pkg::OP_BNE: begin branch = 1'b1; take = ~f[e8cpu_pkg::FLAG_Z]; end
         e8cpu_pkg::OP_BPL: begin branch = 1'b1; take = ~f[e8cpu_pkg::FLAG_N]; end
         e8cpu_pkg::OP_BVC: begin branch = 1'b1; take = ~f[e8cpu_pkg::FLAG_V]; end
         e8cpu_pkg::OP_BVS: begin branch = 1'b1; take =  f[e8cpu_pkg::FLAG_V]; end
         e8cpu_pkg::OP_BIT: begin
            res.arch.flags[e8cpu_pkg::FLAG_N] = m[7];
            res.arch.flags[e8cpu_pkg::FLAG_V] = m[6];
            res.arch.flags[e8cpu_pkg::FLAG_Z] = ((m & a) == 8'h00);
         end
         e8cpu_pkg::OP_BRK: begin
            res.wr_count = 2'd3;
            res.wr_addr0 = e8cpu_pkg::STACK_BASE | {8'h00, sp};
            res.wr_addr1 = e8cpu_pkg::STACK_BASE | {8'h00, sp - 8'd1};
            res.wr_addr2 = e8cpu_pkg::STACK_BASE | {8'h00, sp - 8'd2};
            res.wr_data0 = t_brk[15:8];
            res.wr_data1 = t_brk[7:0];
            res.wr_data2 = push_f;
            res.arch.sp  = sp - 8'd3;
            res.arch.flags = f | 8'h14;
            res.break_hit = 1'b1;
         end
         e8cpu_pkg::OP_CLC: res.arch.flags[e8cpu_pkg::FLAG_C] = 1'b0;
         e8cpu_pkg::OP_CLD: res.arch.flags[e8cpu_pkg::FLAG_D] = 1'b0;
         e8cpu_pkg::OP_CLI: res.arch.flags[e8cpu_pkg::FLAG_I] = 1'b0;
         e8cpu_pkg::OP_CLV: res.arch.flags[e8cpu_pkg::FLAG_V] = 1'b0;
         e8cpu_pkg::OP_SEC: res.arch.flags[e8cpu_pkg::FLAG_C] = 1'b1;
         e8cpu_pkg::OP_SED: res.arch.flags[e8cpu_pkg::FLAG_D] = 1'b1;
         e8cpu_pkg::OP_SEI: res.arch.flags[e8cpu_pkg::FLAG_I] = 1'b1;
         e8cpu_pkg::OP_CMP, e8cpu_pkg::OP_CPX, e8cpu_pkg::OP_CPY: begin
            unique case (req.req_type)
               e8cpu_pkg::OP_CMP: v = a;
               e8cpu_pkg::OP_CPX: v = cur.x;
               default:           v = cur.y;
            endcase
            res.arch.flags[e8cpu_pkg::FLAG_C] = (v >= m);
            sum = {1'b0, v - m};
         end
         e8cpu_pkg::OP_DEC, e8cpu_pkg::OP_INC: begin
            v = (req.req_type == e8cpu_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
            res.wr_count = 2'd1;
            res.wr_addr0 = req.operand_address;
            res.wr_data0 = v;
         end
         e8cpu_pkg::OP_DEX: res.arch.x = cur.x - 8'd1;
         e8cpu_pkg::OP_DEY: res.arch.y = cur.y - 8'd1;
         e8cpu_pkg::OP_INX: res.arch.x = cur.x + 8'd1;
         e8cpu_pkg::OP_INY: res.arch.y = cur.y + 8'd1;
         e8cpu_pkg::OP_JMP: begin
            res.pc_load = 1'b1;
            res.next_pc = req.operand_address;
         end
         e8cpu_pkg::OP_JSR: begin
            res.wr_count = 2'd2;
            res.wr_addr0 = e8cpu_pkg::STACK_BASE | {8'h00, sp};
            res.wr_addr1 = e8cpu_pkg::STACK_BASE | {8'h00, sp - 8'd1};
            res.wr_data0 = t_jsr[15:8];
            res.wr_data1 = t_jsr[7:0];
            res.arch.sp  = sp - 8'd2;
            res.pc_load  = 1'b1;
            res.next_pc  = req.operand_address;
         end
         e8cpu_pkg::OP_LDA: res.arch.acc = m;
         e8cpu_pkg::OP_LDX: res.arch.x = m;
         e8cpu_pkg::OP_LDY: res.arch.y = m;
         e8cpu_pkg::OP_PHA, e8cpu_pkg::OP_PHP: begin
            res.wr_count = 2'd1;
            res.wr_addr0 = e8cpu_pkg::STACK_BASE | {8'h00, sp};
            res.wr_data0 = (req.req_type == e8cpu_pkg::OP_PHA) ? a : push_f;
            res.arch.sp  = sp - 8'd1;
         end
         e8cpu_pkg::OP_PLA: begin
            res.arch.sp  = sp + 8'd1;
            res.arch.acc = req.stack_byte_one;
         end
         e8cpu_pkg::OP_PLP: begin
            res.arch.sp    = sp + 8'd1;
            res.arch.flags = pulled;
         end
         e8cpu_pkg::OP_RTI: begin
            res.arch.sp    = sp + 8'd3;
            res.arch.flags = pulled;
            res.pc_load    = 1'b1;
            res.next_pc    = {req.stack_byte_three, req.stack_byte_two};
         end
         e8cpu_pkg::OP_RTS: begin
            res.arch.sp = sp + 8'd2;
            res.pc_load = 1'b1;
            res.next_pc = {req.stack_byte_two, req.stack_byte_one} + 16'd1;
         end
         e8cpu_pkg::OP_STA, e8cpu_pkg::OP_STX, e8cpu_pkg::OP_STY: begin
            res.wr_count = 2'd1;
            res.wr_addr0 = req.operand_address;
            unique case (req.req_type)
               e8cpu_pkg::OP_STA: res.wr_data0 = a;
               e8cpu_pkg::OP_STX: res.wr_data0 = cur.x;
               default:           res.wr_data0 = cur.y;
            endcase
         end
         e8cpu_pkg::OP_TAX: res.arch.x = a;
         e8cpu_pkg::OP_TAY: res.arch.y = a;
         e8cpu_pkg::OP_TSX: res.arch.x = sp;
         e8cpu_pkg::OP_TXA: res.arch.acc = cur.x;
         e8cpu_pkg::OP_TXS: res.arch.sp = cur.x;
         e8cpu_pkg::OP_TYA: res.arch.acc = cur.y;
         default: ;
      endcase

      // Update N and Z from the value each group of operations produces.
      unique case (req.req_type)
         e8cpu_pkg::OP_ADC, e8cpu_pkg::OP_SBC, e8cpu_pkg::OP_AND, e8cpu_pkg::OP_EOR,
         e8cpu_pkg::OP_ORA, e8cpu_pkg::OP_LDA, e8cpu_pkg::OP_PLA, e8cpu_pkg::OP_TXA,
         e8cpu_pkg::OP_TYA:
            v = res.arch.acc;
         e8cpu_pkg::OP_DEX, e8cpu_pkg::OP_INX, e8cpu_pkg::OP_LDX, e8cpu_pkg::OP_TAX,
         e8cpu_pkg::OP_TSX:
            v = res.arch.x;
         e8cpu_pkg::OP_DEY, e8cpu_pkg::OP_INY, e8cpu_pkg::OP_LDY, e8cpu_pkg::OP_TAY:
            v = res.arch.y;
         e8cpu_pkg::OP_CMP, e8cpu_pkg::OP_CPX, e8cpu_pkg::OP_CPY:
            v = sum[7:0];
         default: ;
      endcase
      unique case (req.req_type)
         e8cpu_pkg::OP_ADC, e8cpu_pkg::OP_SBC, e8cpu_pkg::OP_AND, e8cpu_pkg::OP_EOR,
         e8cpu_pkg::OP_ORA, e8cpu_pkg::OP_LDA, e8cpu_pkg::OP_PLA, e8cpu_pkg::OP_TXA,
         e8cpu_pkg::OP_TYA, e8cpu_pkg::OP_DEX, e8cpu_pkg::OP_INX, e8cpu_pkg::OP_LDX,
         e8cpu_pkg::OP_TAX, e8cpu_pkg::OP_TSX, e8cpu_pkg::OP_DEY, e8cpu_pkg::OP_INY,
         e8cpu_pkg::OP_LDY, e8cpu_pkg::OP_TAY, e8cpu_pkg::OP_CMP, e8cpu_pkg::OP_CPX,
         e8cpu_pkg::OP_CPY, e8cpu_pkg::OP_ASL, e8cpu_pkg::OP_LSR, e8cpu_pkg::OP_ROL,
         e8cpu_pkg::OP_ROR, e8cpu_pkg::OP_DEC, e8cpu_pkg::OP_INC: begin
            res.arch.flags[e8cpu_pkg::FLAG_Z] = (v == 8'h00);
            res.arch.flags[e8cpu_pkg::FLAG_N] = v[7];
         end
         default: ;
      endcase

      if (branch && take) begin
         res.pc_load     = 1'b1;
         res.next_pc     = req.operand_address;
         res.extra_cycle = 1'b1;
      end
   end

endmodule

@@ design/eight_bit_cpu_execute_unit.sv @@
// Top level of the 8-bit CPU execute unit: register file, execute logic and result stage.
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_tvalid/req_tready | req_tdata
//   rsp_     | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tlast
//
// A request executes in the cycle it is accepted; its results are registered and the first appears in the next cycle.
// Each request gives one result per memory write, or one when it writes nothing, one per cycle
// while rsp_tready is high, so the write count sets how many results it gives, up to three.
// A new request is taken in the cycle the last result of the previous one leaves.
// Reset loads SP with 0xFD, flags with 0x24, clears A, X, Y and empties the result stage.
module eight_bit_cpu_execute_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_type[5:0], accumulator_mode, operand_address[15:0], operand_byte[7:0],
   // pc_now[15:0], stack_byte_one, stack_byte_two, stack_byte_three; pad to 72
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mem_write, write_address[15:0], wr_byte[7:0], pc_load, next_pc[15:0],
   // extra_cycle, break_hit, flag_bits, accumulator, index_x, index_y; pad to 80
   output logic [79:0]  rsp_tdata,
   output logic         rsp_tlast
);

   e8cpu_pkg::req_type_t_type req;
   e8cpu_pkg::arch_type       arch_ff, arch_in;
   e8cpu_pkg::exec_type       exe, res_ff, res_in;
   logic                      valid_ff, valid_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      accept, last_out, wr_now;
   logic [15:0]               waddr;
   logic [7:0]                wdata;

   assign req.req_type         = req_tdata[5:0];
   assign req.accumulator_mode = req_tdata[6];
   assign req.operand_address  = req_tdata[22:7];
   assign req.operand_byte     = req_tdata[30:23];
   assign req.pc_now           = req_tdata[46:31];
   assign req.stack_byte_one   = req_tdata[54:47];
   assign req.stack_byte_two   = req_tdata[62:55];
   assign req.stack_byte_three = req_tdata[70:63];

   e8cpu_alu u_alu (
      .req (req),
      .cur (arch_ff),
      .res (exe)
   );

   // The final result of a request is the one at the last write, or the only one.
   assign last_out   = (res_ff.wr_count == 2'd0) || (idx_ff == res_ff.wr_count - 2'd1);
   assign req_tready = ~valid_ff || (rsp_tready && last_out);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      arch_in  = arch_ff;
      res_in   = res_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && rsp_tready) begin
         if (last_out) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (accept) begin
         arch_in  = exe.arch;
         res_in   = exe;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff.acc   <= 8'h00;
         arch_ff.x     <= 8'h00;
         arch_ff.y     <= 8'h00;
         arch_ff.sp    <= e8cpu_pkg::SP_RESET;
         arch_ff.flags <= e8cpu_pkg::FLAGS_RESET;
         valid_ff      <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         arch_ff  <= arch_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      res_ff <= res_in;
   end

   always_comb begin
      wr_now = (res_ff.wr_count != 2'd0);
      unique case (idx_ff)
         2'd0:    begin waddr = res_ff.wr_addr0; wdata = res_ff.wr_data0; end
         2'd1:    begin waddr = res_ff.wr_addr1; wdata = res_ff.wr_data1; end
         default: begin waddr = res_ff.wr_addr2; wdata = res_ff.wr_data2; end
      endcase
      if (!wr_now) begin
         waddr = 16'h0000;
         wdata = 8'h00;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_out;
   assign rsp_tdata  = {4'h0,
                        res_ff.arch.y, res_ff.arch.x, res_ff.arch.acc, res_ff.arch.flags,
                        res_ff.break_hit, res_ff.extra_cycle,
                        (res_ff.pc_load ? res_ff.next_pc : 16'h0000), res_ff.pc_load,
                        wdata, waddr, wr_now};

`ifndef SYNTHESIS
   a_tready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> req_tready) else $error("request not taken while empty");
   a_last_only_final: assert property (@(posedge clock) disable iff (reset)
      valid_ff && idx_ff != 2'd0 |-> res_ff.wr_count != 2'd0)
      else $error("write index beyond write count");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !last_out |=> valid_ff && idx_ff == $past(idx_ff) + 2'd1)
      else $error("write sequence did not advance");
`endif

endmodule
